@@ design/rwhp_pkg.sv @@
package rwhp_pkg;

    // Parser phases
    typedef enum logic [1:0] {
        PH_PREAMBLE,
        PH_HEADER,
        PH_FMT,
        PH_SKIP
    } phase_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_RIFF  = 3'd1,
        ST_NOT_WAVE  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_SHORT_FMT = 3'd4
    } status_t;

    // Four-character codes, first character in the top byte
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Preamble and chunk header layout
    localparam logic [4:0] PRE_LAST      = 5'd11;
    localparam logic [4:0] WAVE_FIRST    = 5'd8;
    localparam logic [4:0] HDR_TAG_LAST  = 5'd3;
    localparam logic [4:0] HDR_LAST      = 5'd7;
    localparam logic [4:0] FMT_LAST      = 5'd15;
    localparam logic [31:0] FMT_CAPTURE  = 32'd16;

    // Chunk kind flags while a header tag is compared
    localparam logic [1:0] KIND_FMT  = 2'b01;
    localparam logic [1:0] KIND_DATA = 2'b10;
    localparam logic [1:0] KIND_BOTH = 2'b11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [31:0] sample_hz;
        logic [15:0] bits_per_sample;
        logic [31:0] data_size;
        logic [31:0] data_start;
    } result_t;

    // Pick character pos (0 = first) of a four-character code
    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] pos);
        logic [4:0] sh;
        sh = {~pos, 3'b000};
        return tag[sh +: 8];
    endfunction

endpackage

@@ design/rwhp_chan_if.sv @@
interface rwhp_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/rwhp_core.sv @@
module rwhp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  rwhp_pkg::in_item_t item,
    output logic               emit,
    output rwhp_pkg::result_t  result
);

    rwhp_pkg::phase_t phase_reg, phase_next, phase_b;
    logic [4:0]  idx_reg, idx_next, idx_b;
    logic [31:0] word_reg, word_next, word_b;
    logic [1:0]  tag_reg, tag_next, tag_b;
    logic [31:0] left_reg, left_next, left_b;
    logic [31:0] seen_reg, seen_next, seen_b;
    logic [15:0] fmt_format_reg, fmt_format_next, fmt_format_b;
    logic [15:0] fmt_chan_reg, fmt_chan_next, fmt_chan_b;
    logic [31:0] fmt_rate_reg, fmt_rate_next, fmt_rate_b;
    logic [15:0] fmt_bits_reg, fmt_bits_next, fmt_bits_b;
    logic        fin_reg, fin_next, fin_b;

    logic                done;
    rwhp_pkg::status_t   done_code;

    // Restart from a clean file when the first byte is flagged
    always_comb
    begin
        if (item.first_byte)
        begin
            phase_b      = rwhp_pkg::PH_PREAMBLE;
            idx_b        = '0;
            word_b       = '0;
            tag_b        = '0;
            left_b       = '0;
            seen_b       = '0;
            fmt_format_b = '0;
            fmt_chan_b   = '0;
            fmt_rate_b   = '0;
            fmt_bits_b   = '0;
            fin_b        = 1'b0;
        end
        else
        begin
            phase_b      = phase_reg;
            idx_b        = idx_reg;
            word_b       = word_reg;
            tag_b        = tag_reg;
            left_b       = left_reg;
            seen_b       = seen_reg;
            fmt_format_b = fmt_format_reg;
            fmt_chan_b   = fmt_chan_reg;
            fmt_rate_b   = fmt_rate_reg;
            fmt_bits_b   = fmt_bits_reg;
            fin_b        = fin_reg;
        end
    end

    // Next state for one byte
    always_comb
    begin
        logic [7:0] b;
        logic [1:0] tag_tmp;
        b = item.data_byte;
        tag_tmp = tag_b;

        phase_next      = phase_b;
        idx_next        = idx_b;
        word_next       = word_b;
        tag_next        = tag_b;
        left_next       = left_b;
        seen_next       = seen_b;
        fmt_format_next = fmt_format_b;
        fmt_chan_next   = fmt_chan_b;
        fmt_rate_next   = fmt_rate_b;
        fmt_bits_next   = fmt_bits_b;
        fin_next        = fin_b;
        done            = 1'b0;
        done_code       = rwhp_pkg::ST_OK;

        if (item.stream_end)
        begin
            if (!fin_b)
            begin
                done      = 1'b1;
                done_code = rwhp_pkg::ST_TRUNCATED;
            end
        end
        else if (!fin_b)
        begin
            // Count bytes, saturating
            if (seen_b != '1)
            begin
                seen_next = seen_b + 32'd1;
            end

            case (phase_b)
                rwhp_pkg::PH_PREAMBLE:
                begin
                    if (idx_b < 5'd4 && b != rwhp_pkg::tag_byte(rwhp_pkg::TAG_RIFF, idx_b[1:0]))
                    begin
                        tag_tmp[0] = 1'b1;
                    end
                    if (idx_b >= rwhp_pkg::WAVE_FIRST
                        && b != rwhp_pkg::tag_byte(rwhp_pkg::TAG_WAVE, idx_b[1:0]))
                    begin
                        tag_tmp[1] = 1'b1;
                    end
                    tag_next = tag_tmp;
                    if (idx_b >= rwhp_pkg::PRE_LAST)
                    begin
                        if (tag_tmp[0])
                        begin
                            done      = 1'b1;
                            done_code = rwhp_pkg::ST_NOT_RIFF;
                        end
                        else if (tag_tmp[1])
                        begin
                            done      = 1'b1;
                            done_code = rwhp_pkg::ST_NOT_WAVE;
                        end
                        else
                        begin
                            tag_next   = '0;
                            phase_next = rwhp_pkg::PH_HEADER;
                            idx_next   = '0;
                        end
                    end
                    else
                    begin
                        idx_next = idx_b + 5'd1;
                    end
                end

                rwhp_pkg::PH_HEADER:
                begin
                    if (idx_b <= rwhp_pkg::HDR_TAG_LAST)
                    begin
                        // Compare the chunk tag against both known kinds
                        if (idx_b == '0)
                        begin
                            tag_tmp = rwhp_pkg::KIND_BOTH;
                        end
                        if (b != rwhp_pkg::tag_byte(rwhp_pkg::TAG_FMT, idx_b[1:0]))
                        begin
                            tag_tmp[0] = 1'b0;
                        end
                        if (b != rwhp_pkg::tag_byte(rwhp_pkg::TAG_DATA, idx_b[1:0]))
                        begin
                            tag_tmp[1] = 1'b0;
                        end
                        tag_next = tag_tmp;
                        if (idx_b == rwhp_pkg::HDR_TAG_LAST)
                        begin
                            word_next = '0;
                        end
                        idx_next = idx_b + 5'd1;
                    end
                    else
                    begin
                        // Collect the little-endian chunk size
                        word_next = word_b | ({24'd0, b} << {idx_b[1:0], 3'b000});
                        if (idx_b < rwhp_pkg::HDR_LAST)
                        begin
                            idx_next = idx_b + 5'd1;
                        end
                        else if (tag_b == rwhp_pkg::KIND_DATA)
                        begin
                            done      = 1'b1;
                            done_code = rwhp_pkg::ST_OK;
                        end
                        else if (tag_b == rwhp_pkg::KIND_FMT)
                        begin
                            if (word_next < rwhp_pkg::FMT_CAPTURE)
                            begin
                                done      = 1'b1;
                                done_code = rwhp_pkg::ST_SHORT_FMT;
                            end
                            else
                            begin
                                left_next  = word_next - rwhp_pkg::FMT_CAPTURE;
                                phase_next = rwhp_pkg::PH_FMT;
                                idx_next   = '0;
                            end
                        end
                        else
                        begin
                            left_next  = word_next;
                            phase_next = (word_next != '0) ? rwhp_pkg::PH_SKIP
                                                           : rwhp_pkg::PH_HEADER;
                            idx_next   = '0;
                        end
                    end
                end

                rwhp_pkg::PH_FMT:
                begin
                    // Capture the fields of the first 16 fmt bytes
                    case (idx_b[3:0]) inside
                        [4'd0 : 4'd1]:
                            fmt_format_next[{idx_b[0], 3'b000} +: 8] = b;
                        [4'd2 : 4'd3]:
                            fmt_chan_next[{idx_b[0], 3'b000} +: 8] = b;
                        [4'd4 : 4'd7]:
                            fmt_rate_next[{idx_b[1:0], 3'b000} +: 8] = b;
                        [4'd14 : 4'd15]:
                            fmt_bits_next[{idx_b[0], 3'b000} +: 8] = b;
                        default:
                            fmt_format_next = fmt_format_b;
                    endcase
                    if (idx_b >= rwhp_pkg::FMT_LAST)
                    begin
                        phase_next = (left_b != '0) ? rwhp_pkg::PH_SKIP : rwhp_pkg::PH_HEADER;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_b + 5'd1;
                    end
                end

                default:
                begin
                    // Skip the body of an unused chunk
                    if (left_b != '0)
                    begin
                        left_next = left_b - 32'd1;
                    end
                    if (left_next == '0)
                    begin
                        phase_next = rwhp_pkg::PH_HEADER;
                        idx_next   = '0;
                    end
                end
            endcase
        end

        if (done)
        begin
            fin_next = 1'b1;
        end
    end

    // Form the result; fields other than status stay zero on error
    always_comb
    begin
        emit   = step && done;
        result = '0;
        result.status = done_code;
        if (done_code == rwhp_pkg::ST_OK)
        begin
            result.audio_format    = fmt_format_next;
            result.channel_count   = fmt_chan_next;
            result.sample_hz       = fmt_rate_next;
            result.bits_per_sample = fmt_bits_next;
            result.data_size       = word_next;
            result.data_start      = seen_next;
        end
    end

    // Advance parser state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= rwhp_pkg::PH_PREAMBLE;
            idx_reg        <= '0;
            word_reg       <= '0;
            tag_reg        <= '0;
            left_reg       <= '0;
            seen_reg       <= '0;
            fmt_format_reg <= '0;
            fmt_chan_reg   <= '0;
            fmt_rate_reg   <= '0;
            fmt_bits_reg   <= '0;
            fin_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            word_reg       <= word_next;
            tag_reg        <= tag_next;
            left_reg       <= left_next;
            seen_reg       <= seen_next;
            fmt_format_reg <= fmt_format_next;
            fmt_chan_reg   <= fmt_chan_next;
            fmt_rate_reg   <= fmt_rate_next;
            fmt_bits_reg   <= fmt_bits_next;
            fin_reg        <= fin_next;
        end
    end

endmodule

@@ design/rwhp_out_queue.sv @@
module rwhp_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rwhp_pkg::result_t push_data,
    output logic              full,
    rwhp_chan_if.source       report
);

    logic [1:0]        count_reg, count_next;
    rwhp_pkg::result_t head_reg, head_next;
    rwhp_pkg::result_t tail_reg, tail_next;
    logic              pop;

    assign pop          = (count_reg != 2'd0) && report.ready;
    assign full         = (count_reg == 2'd2);
    assign report.valid = (count_reg != 2'd0);
    assign report.data  = head_reg;

    // Two-entry result buffer: head drives the port, tail holds a second result
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (pop && push)
        begin
            if (count_reg == 2'd1)
            begin
                head_next = push_data;
            end
            else
            begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end
        else if (pop)
        begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                head_next = push_data;
            end
            else
            begin
                tail_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end
    end

    // Hold count under reset; payload needs none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

@@ design/riff_wave_header_parser_top.sv @@
// RIFF/WAVE header parser.
// feed (sink) takes one file byte per transfer: data_byte, first_byte marks
// byte 0 of a new file and restarts the parse, stream_end marks the end of
// the file and carries no byte. report (source) gives one result per file:
// status, the fmt fields, the data chunk size and the offset of the first
// data byte; on an error status all other fields are zero.
// A result enters the output buffer with the transfer of the byte (or end
// mark) that completes it; report offers the head of that buffer.
// Throughput: one byte per cycle while feed.ready is high. The parser state
// updates in the cycle of each transfer; results go to a two-entry buffer.
// When report stalls, feed keeps taking bytes until two results wait in the
// buffer; feed.ready then drops until report takes one.
// Reset clears the parser to the start of a file and empties the buffer.
// Bytes after a finished file are dropped until first_byte is set again.
module riff_wave_header_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    rwhp_chan_if.sink   feed,
    rwhp_chan_if.source report
);

    logic              step;
    logic              emit;
    logic              full;
    rwhp_pkg::result_t result;

    assign feed.ready = !full;
    assign step       = feed.valid && !full;

    rwhp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (feed.data),
        .emit   (emit),
        .result (result)
    );

    rwhp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (result),
        .full      (full),
        .report    (report)
    );

endmodule

@@ design/rwhp_checker.sv @@
module rwhp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input rwhp_pkg::result_t out_data
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result payload changed while stalled");

    // Error results carry nothing but status
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != rwhp_pkg::ST_OK |->
            out_data.audio_format == '0 && out_data.channel_count == '0
            && out_data.sample_hz == '0 && out_data.bits_per_sample == '0
            && out_data.data_size == '0 && out_data.data_start == '0)
        else $error("error result with nonzero fields");

    // Data starts after at least the preamble and one chunk header
    a_min_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == rwhp_pkg::ST_OK |->
            out_data.data_start >= 32'd20)
        else $error("data offset below minimum header size");

endmodule

bind riff_wave_header_parser_top rwhp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (report.valid),
    .out_ready (report.ready),
    .out_data  (report.data)
);

@@ tb/riff_wave_header_parser_top_test.sv @@
`timescale 1ns / 1ps

module riff_wave_header_parser_top_test;

    // Four-character codes, first character in the top byte
    localparam logic [31:0] RIFF_ID = "RIFF";
    localparam logic [31:0] WAVE_ID = "WAVE";
    localparam logic [31:0] FMT_ID  = "fmt ";
    localparam logic [31:0] DATA_ID = "data";
    localparam logic [31:0] LIST_ID = "LIST";
    localparam logic [31:0] JUNK_ID = "junk";

    // File layout
    localparam logic [4:0]  WAVE_AT      = 5'd8;
    localparam logic [4:0]  PREAMBLE_END = 5'd11;
    localparam logic [4:0]  HDR_TAG_END  = 5'd3;
    localparam logic [4:0]  HDR_END      = 5'd7;
    localparam logic [4:0]  FMT_END      = 5'd15;
    localparam logic [31:0] FMT_BODY     = 32'd16;

    // Chunk tag match flags during a header
    localparam logic [1:0] TAG_IS_FMT  = 2'b01;
    localparam logic [1:0] TAG_IS_DATA = 2'b10;
    localparam logic [1:0] TAG_ANY     = 2'b11;

    localparam int unsigned RANDOM_ITEMS = 1070;
    localparam int unsigned MIN_FILES    = 24;
    localparam int unsigned STALL_LIMIT  = 400;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef enum {
        DC_NO_FIRST,
        DC_EMPTY,
        DC_SHORT_PREAMBLE,
        DC_NOT_RIFF,
        DC_NOT_WAVE,
        DC_BOTH_BAD,
        DC_SHORT_FMT,
        DC_FMT_MAX,
        DC_AFTER_FINISH,
        DC_FMT_ZERO,
        DC_NO_FMT,
        DC_SKIPPED_CHUNKS,
        DC_TWO_FMT,
        DC_CUT_IN_FMT
    } dir_case_t;

    typedef struct {
        dir_case_t         kind;
        bit                typed;
        rwhp_pkg::result_t want;
    } dir_row_t;

    typedef struct {
        rwhp_pkg::in_item_t item;
        bit                 typed;
        rwhp_pkg::result_t  want;
    } plan_entry_t;

    logic clk;
    logic rst_n;

    rwhp_chan_if #(.T(rwhp_pkg::in_item_t)) feed_ch ();
    rwhp_chan_if #(.T(rwhp_pkg::result_t))  report_ch ();

    riff_wave_header_parser_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_ch),
        .report (report_ch)
    );

    plan_entry_t       byte_plan [$];
    rwhp_pkg::result_t pending_reports [$];
    dir_row_t          dir_table [14];

    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned files_sent;
    int unsigned reports_seen;
    int unsigned status_seen [8];
    bit          feed_calm;
    bit          report_calm;

    // Parser state of the prediction
    rwhp_pkg::phase_t p_phase;
    logic [4:0]  p_idx;
    logic [31:0] p_word;
    logic [1:0]  p_kind;
    logic [31:0] p_left;
    logic [31:0] p_count;
    logic [63:0] p_fmt_lo;
    logic [63:0] p_fmt_hi;
    bit          p_done;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic void parse_restart();
        p_phase  = rwhp_pkg::PH_PREAMBLE;
        p_idx    = '0;
        p_word   = '0;
        p_kind   = '0;
        p_left   = '0;
        p_count  = '0;
        p_fmt_lo = '0;
        p_fmt_hi = '0;
        p_done   = 1'b0;
    endfunction

    function automatic logic [7:0] char_of(input logic [31:0] tag, input logic [1:0] pos);
        return 8'(tag >> (24 - 8 * pos));
    endfunction

    // Close the file; error reports carry nothing but the status
    function automatic rwhp_pkg::result_t close_file(input rwhp_pkg::status_t st);
        rwhp_pkg::result_t r;
        r = '0;
        r.status = st;
        if (st == rwhp_pkg::ST_OK)
        begin
            r.audio_format    = p_fmt_lo[15:0];
            r.channel_count   = p_fmt_lo[31:16];
            r.sample_hz       = p_fmt_lo[63:32];
            r.bits_per_sample = p_fmt_hi[63:48];
            r.data_size       = p_word;
            r.data_start      = p_count;
        end
        p_done = 1'b1;
        return r;
    endfunction

    // Advance the parse by one transfer; return 1 when it yields a report
    function automatic bit report_for_byte(input rwhp_pkg::in_item_t it,
                                           output rwhp_pkg::result_t res);
        logic [7:0] b;
        logic [4:0] idx;
        b   = it.data_byte;
        res = '0;
        if (it.first_byte)
            parse_restart();
        idx = p_idx;
        if (it.stream_end)
        begin
            if (p_done)
                return 1'b0;
            res = close_file(rwhp_pkg::ST_TRUNCATED);
            return 1'b1;
        end
        if (p_done)
            return 1'b0;
        if (p_count != 32'hFFFF_FFFF)
            p_count = p_count + 32'd1;

        case (p_phase)
            rwhp_pkg::PH_PREAMBLE:
            begin
                if (idx <= HDR_TAG_END && b != char_of(RIFF_ID, idx[1:0]))
                    p_kind[0] = 1'b1;
                if (idx >= WAVE_AT && b != char_of(WAVE_ID, idx[1:0]))
                    p_kind[1] = 1'b1;
                if (idx >= PREAMBLE_END)
                begin
                    if (p_kind[0])
                    begin
                        res = close_file(rwhp_pkg::ST_NOT_RIFF);
                        return 1'b1;
                    end
                    if (p_kind[1])
                    begin
                        res = close_file(rwhp_pkg::ST_NOT_WAVE);
                        return 1'b1;
                    end
                    p_kind  = '0;
                    p_phase = rwhp_pkg::PH_HEADER;
                    p_idx   = '0;
                end
                else
                    p_idx = idx + 5'd1;
            end

            rwhp_pkg::PH_HEADER:
            begin
                if (idx <= HDR_TAG_END)
                begin
                    if (idx == 5'd0)
                        p_kind = TAG_ANY;
                    if (b != char_of(FMT_ID, idx[1:0]))
                        p_kind = p_kind & ~TAG_IS_FMT;
                    if (b != char_of(DATA_ID, idx[1:0]))
                        p_kind = p_kind & ~TAG_IS_DATA;
                    if (idx == HDR_TAG_END)
                        p_word = '0;
                    p_idx = idx + 5'd1;
                end
                else
                begin
                    // Size field, little endian
                    p_word = p_word | (32'(b) << (8 * idx[1:0]));
                    if (idx < HDR_END)
                        p_idx = idx + 5'd1;
                    else if (p_kind == TAG_IS_DATA)
                    begin
                        res = close_file(rwhp_pkg::ST_OK);
                        return 1'b1;
                    end
                    else if (p_kind == TAG_IS_FMT)
                    begin
                        if (p_word < FMT_BODY)
                        begin
                            res = close_file(rwhp_pkg::ST_SHORT_FMT);
                            return 1'b1;
                        end
                        p_left  = p_word - FMT_BODY;
                        p_phase = rwhp_pkg::PH_FMT;
                        p_idx   = '0;
                    end
                    else
                    begin
                        p_left  = p_word;
                        p_phase = (p_word != 0) ? rwhp_pkg::PH_SKIP : rwhp_pkg::PH_HEADER;
                        p_idx   = '0;
                    end
                end
            end

            rwhp_pkg::PH_FMT:
            begin
                if (idx[3])
                    p_fmt_hi[8 * idx[2:0] +: 8] = b;
                else
                    p_fmt_lo[8 * idx[2:0] +: 8] = b;
                if (idx >= FMT_END)
                begin
                    p_phase = (p_left != 0) ? rwhp_pkg::PH_SKIP : rwhp_pkg::PH_HEADER;
                    p_idx   = '0;
                end
                else
                    p_idx = idx + 5'd1;
            end

            default:
            begin
                if (p_left != 0)
                    p_left = p_left - 32'd1;
                if (p_left == 0)
                begin
                    p_phase = rwhp_pkg::PH_HEADER;
                    p_idx   = '0;
                end
            end
        endcase
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus construction
    // ---------------------------------------------------------------

    function automatic void push_item(input logic [7:0] b, input bit first, input bit fin);
        plan_entry_t e;
        e.item.data_byte  = b;
        e.item.first_byte = first;
        e.item.stream_end = fin;
        e.typed = 1'b0;
        e.want  = '0;
        byte_plan.push_back(e);
    endfunction

    function automatic void push_end(input bit first);
        push_item(8'($urandom_range(0, 255)), first, 1'b1);
    endfunction

    function automatic void push_fill(input int unsigned len);
        repeat (len)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endfunction

    function automatic void push_le(input logic [31:0] value, input int unsigned len);
        for (int i = 0; i < len; i++)
            push_item(8'(value >> (8 * i)), 1'b0, 1'b0);
    endfunction

    function automatic void push_tag(input logic [31:0] tag, input bit first);
        for (int i = 0; i < 4; i++)
            push_item(char_of(tag, 2'(i)), first && i == 0, 1'b0);
    endfunction

    function automatic void push_preamble(input logic [31:0] riff, input logic [31:0] wave,
                                          input bit first);
        push_tag(riff, first);
        push_le($urandom(), 4);
        push_tag(wave, 1'b0);
    endfunction

    function automatic void push_chunk(input logic [31:0] tag, input logic [31:0] len);
        push_tag(tag, 1'b0);
        push_le(len, 4);
    endfunction

    // fmt chunk; a size below the captured length gets the header only
    function automatic void push_fmt(input logic [31:0] len, input logic [15:0] fmt,
                                     input logic [15:0] chans, input logic [31:0] rate,
                                     input logic [15:0] bits);
        push_chunk(FMT_ID, len);
        if (len >= FMT_BODY)
        begin
            push_le(32'(fmt), 2);
            push_le(32'(chans), 2);
            push_le(rate, 4);
            push_le($urandom(), 4);
            push_le($urandom_range(0, 65535), 2);
            push_le(32'(bits), 2);
            push_fill(len - FMT_BODY);
        end
    endfunction

    function automatic void mark_want(input rwhp_pkg::result_t r);
        byte_plan[byte_plan.size() - 1].typed = 1'b1;
        byte_plan[byte_plan.size() - 1].want  = r;
    endfunction

    function automatic rwhp_pkg::result_t bad_report(input rwhp_pkg::status_t st);
        rwhp_pkg::result_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic rwhp_pkg::result_t ok_report(input logic [15:0] fmt,
                                                    input logic [15:0] chans,
                                                    input logic [31:0] rate,
                                                    input logic [15:0] bits,
                                                    input logic [31:0] len,
                                                    input logic [31:0] offset);
        rwhp_pkg::result_t r;
        r = '{rwhp_pkg::ST_OK, fmt, chans, rate, bits, len, offset};
        return r;
    endfunction

    function automatic void push_directed();
        dir_row_t row;
        foreach (dir_table[i])
        begin
            row = dir_table[i];
            case (row.kind)
                DC_NO_FIRST:
                begin
                    push_preamble(RIFF_ID, WAVE_ID, 1'b0);
                    push_chunk(DATA_ID, 32'd7);
                end
                DC_EMPTY:
                    push_end(1'b1);
                DC_SHORT_PREAMBLE:
                begin
                    push_tag(RIFF_ID, 1'b1);
                    push_le(32'h0, 2);
                    push_end(1'b0);
                end
                DC_NOT_RIFF:
                    push_preamble(RIFF_ID ^ 32'h1, WAVE_ID, 1'b1);
                DC_NOT_WAVE:
                    push_preamble(RIFF_ID, WAVE_ID ^ 32'h0000_0100, 1'b1);
                DC_BOTH_BAD:
                    for (int j = 0; j < 12; j++)
                        push_item(8'hFF, j == 0, 1'b0);
                DC_SHORT_FMT:
                begin
                    push_preamble(RIFF_ID, WAVE_ID, 1'b1);
                    push_fmt(32'd15, '0, '0, '0, '0);
                end
                DC_FMT_MAX:
                begin
                    push_preamble(RIFF_ID, WAVE_ID, 1'b1);
                    push_fmt(FMT_BODY, '1, '1, '1, '1);
                    push_chunk(DATA_ID, '1);
                end
                DC_AFTER_FINISH:
                begin
                    // finished file: bytes and the end mark are dropped
                    push_fill(3);
                    push_end(1'b0);
                end
                DC_FMT_ZERO:
                begin
                    push_preamble(RIFF_ID, WAVE_ID, 1'b1);
                    push_fmt(FMT_BODY, '0, '0, '0, '0);
                    push_chunk(DATA_ID, '0);
                end
                DC_NO_FMT:
                begin
                    push_preamble(RIFF_ID, WAVE_ID, 1'b1);
                    push_chunk(DATA_ID, 32'd1234);
                end
                DC_SKIPPED_CHUNKS:
                begin
                    push_preamble(RIFF_ID, WAVE_ID, 1'b1);
                    push_chunk(LIST_ID, 32'd3);
                    push_fill(3);
                    push_chunk(JUNK_ID, 32'd0);
                    push_chunk(FMT_ID ^ 32'h1, 32'd1);
                    push_fill(1);
                    push_fmt(32'd20, 16'd1, 16'd2, 32'd44100, 16'd16);
                    push_chunk(DATA_ID ^ 32'h0000_0100, 32'd2);
                    push_fill(2);
                    push_chunk(DATA_ID, 32'h0001_0000);
                end
                DC_TWO_FMT:
                begin
                    push_preamble(RIFF_ID, WAVE_ID, 1'b1);
                    push_fmt(FMT_BODY, 16'd3, 16'd1, 32'd8000, 16'd32);
                    push_fmt(32'd18, 16'd1, 16'd6, 32'd96000, 16'd24);
                    push_chunk(DATA_ID, 32'd500);
                end
                default:
                begin
                    push_preamble(RIFF_ID, WAVE_ID, 1'b1);
                    push_chunk(FMT_ID, FMT_BODY);
                    push_fill(5);
                    push_end(1'b0);
                end
            endcase
            if (row.typed)
                mark_want(row.want);
        end
    endfunction

    function automatic logic [31:0] flip_bit(input logic [31:0] tag);
        return tag ^ (32'h1 << $urandom_range(0, 31));
    endfunction

    // Mostly well-formed files with random content; some noise and broken files
    function automatic void push_random_file();
        int unsigned start;
        int unsigned roll;
        int unsigned len;
        int unsigned cut;
        logic [31:0] tag;
        logic [31:0] data_len;
        start = byte_plan.size();
        roll  = $urandom_range(0, 99);
        if (roll < 6)
        begin
            repeat ($urandom_range(1, 24))
                push_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                          $urandom_range(0, 7) == 0);
            return;
        end
        push_preamble(roll < 10 ? flip_bit(RIFF_ID) : RIFF_ID,
                      (roll >= 10 && roll < 14) ? flip_bit(WAVE_ID) : WAVE_ID,
                      $urandom_range(0, 19) != 0);

        repeat ($urandom_range(0, 2))
        begin
            if ($urandom_range(0, 1))
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(16, 22);
                push_fmt(len, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         $urandom(), 16'($urandom_range(0, 65535)));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       tag = flip_bit(FMT_ID);
                    1:       tag = flip_bit(DATA_ID);
                    default: tag = $urandom();
                endcase
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40)
                                                   : $urandom_range(0, 5);
                push_chunk(tag, len);
                push_fill(len);
            end
        end

        case ($urandom_range(0, 7))
            0:       data_len = '0;
            1:       data_len = '1;
            default: data_len = $urandom();
        endcase
        push_chunk(DATA_ID, data_len);

        // Cut short, trail with dropped bytes, close with an end mark, or add nothing
        roll = $urandom_range(0, 99);
        if (roll < 15)
        begin
            cut = $urandom_range(start + 1, byte_plan.size() - 1);
            while (byte_plan.size() > cut)
                void'(byte_plan.pop_back());
            push_end(1'b0);
        end
        else if (roll < 30)
        begin
            push_fill($urandom_range(1, 4));
            push_end(1'b0);
        end
        else if (roll < 40)
            push_end(1'b0);
    endfunction

    // ---------------------------------------------------------------
    // Handshake helpers and checking
    // ---------------------------------------------------------------

    // Draw a wait; now and then switch between idling and back-to-back
    function automatic int unsigned pause_len(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Feed side: reset, stimulus, end of run
    // ---------------------------------------------------------------

    initial
    begin : feed_side
        plan_entry_t        rec;
        rwhp_pkg::result_t  predicted;
        rwhp_pkg::in_item_t noise;
        int unsigned        gap;
        int unsigned        rand_start;
        int unsigned        files_built;

        rst_n         = 1'b0;
        feed_ch.valid = 1'b0;
        feed_ch.data  = '0;
        fail_count    = 0;
        items_sent    = 0;
        files_sent    = 0;
        reports_seen  = 0;
        feed_calm     = 1'b0;
        report_calm   = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        parse_restart();

        dir_table = '{
            '{DC_NO_FIRST,       1'b0, '0},
            '{DC_EMPTY,          1'b1, bad_report(rwhp_pkg::ST_TRUNCATED)},
            '{DC_SHORT_PREAMBLE, 1'b1, bad_report(rwhp_pkg::ST_TRUNCATED)},
            '{DC_NOT_RIFF,       1'b1, bad_report(rwhp_pkg::ST_NOT_RIFF)},
            '{DC_NOT_WAVE,       1'b1, bad_report(rwhp_pkg::ST_NOT_WAVE)},
            '{DC_BOTH_BAD,       1'b1, bad_report(rwhp_pkg::ST_NOT_RIFF)},
            '{DC_SHORT_FMT,      1'b1, bad_report(rwhp_pkg::ST_SHORT_FMT)},
            '{DC_FMT_MAX,        1'b1, ok_report('1, '1, '1, '1, '1, 32'd44)},
            '{DC_AFTER_FINISH,   1'b0, '0},
            '{DC_FMT_ZERO,       1'b1, ok_report('0, '0, '0, '0, '0, 32'd44)},
            '{DC_NO_FMT,         1'b1, ok_report('0, '0, '0, '0, 32'd1234, 32'd20)},
            '{DC_SKIPPED_CHUNKS, 1'b0, '0},
            '{DC_TWO_FMT,        1'b0, '0},
            '{DC_CUT_IN_FMT,     1'b1, bad_report(rwhp_pkg::ST_TRUNCATED)}
        };
        push_directed();

        rand_start  = byte_plan.size();
        files_built = 0;
        while (byte_plan.size() - rand_start < RANDOM_ITEMS || files_built < MIN_FILES)
        begin
            push_random_file();
            files_built++;
        end

        // Hold reset, then release it on a falling clock edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drive each transfer, predict its report on acceptance
        while (byte_plan.size() != 0)
        begin
            rec = byte_plan.pop_front();
            gap = pause_len(feed_calm);
            @(negedge clk);
            if (gap != 0)
            begin
                noise.data_byte  = 8'($urandom_range(0, 255));
                noise.first_byte = 1'($urandom_range(0, 1));
                noise.stream_end = 1'($urandom_range(0, 1));
                feed_ch.valid <= 1'b0;
                feed_ch.data  <= noise;
                repeat (gap) @(negedge clk);
            end
            feed_ch.valid <= 1'b1;
            feed_ch.data  <= rec.item;
            do @(posedge clk); while (!feed_ch.ready);
            items_sent++;
            if (rec.item.first_byte)
                files_sent++;
            if (report_for_byte(rec.item, predicted))
            begin
                if (!rec.typed)
                    pending_reports.push_back(predicted);
            end
            if (rec.typed)
                pending_reports.push_back(rec.want);
        end
        @(negedge clk);
        feed_ch.valid <= 1'b0;

        // Drain outstanding reports, then watch for strays
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes and end marks over %0d files; checked %0d reports.",
                 items_sent, files_sent, reports_seen);
        $display("Status mix: ok %0d, not RIFF %0d, not WAVE %0d, truncated %0d, short fmt %0d.",
                 status_seen[rwhp_pkg::ST_OK], status_seen[rwhp_pkg::ST_NOT_RIFF],
                 status_seen[rwhp_pkg::ST_NOT_WAVE], status_seen[rwhp_pkg::ST_TRUNCATED],
                 status_seen[rwhp_pkg::ST_SHORT_FMT]);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Report side: random stalls, compare against the oldest expectation
    // ---------------------------------------------------------------

    initial
    begin : report_side
        rwhp_pkg::result_t got;
        rwhp_pkg::result_t want;
        int unsigned       hold;

        report_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = pause_len(report_calm);
            if (hold != 0)
            begin
                report_ch.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            report_ch.ready <= 1'b1;
            do @(posedge clk); while (!report_ch.valid);
            got = report_ch.data;
            reports_seen++;
            status_seen[got.status]++;
            if (pending_reports.size() == 0)
            begin
                $error("report with no file pending: status %0d", got.status);
                fail_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("status",          32'(want.status),      32'(got.status));
                check_field("audio_format",    32'(want.audio_format), 32'(got.audio_format));
                check_field("channel_count",   32'(want.channel_count),
                            32'(got.channel_count));
                check_field("sample_hz",       want.sample_hz,        got.sample_hz);
                check_field("bits_per_sample", 32'(want.bits_per_sample),
                            32'(got.bits_per_sample));
                check_field("data_size",       want.data_size,        got.data_size);
                check_field("data_start",      want.data_start,       got.data_start);
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: end the run when neither side moves for too long
    // ---------------------------------------------------------------

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((feed_ch.valid && feed_ch.ready) || (report_ch.valid && report_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transfer for %0d cycles, %0d reports outstanding",
               STALL_LIMIT, pending_reports.size());
        $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
design/rwhp_pkg.sv
design/rwhp_chan_if.sv
design/rwhp_core.sv
design/rwhp_out_queue.sv
design/riff_wave_header_parser_top.sv
design/rwhp_checker.sv
tb/riff_wave_header_parser_top_test.sv
